FILE: hw/rtl/bdra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdra_pkg
// Shared types and constants of the button debounce and rate adjust block:
// register reset values, register indexes, request codes and the
// configuration bundle passed from the register file to the core.
// ----------------------------------------------------------------------------
package bdra_pkg;

    // register reset values
    localparam logic [7:0] BASE_DEBOUNCE_RESET   = 8'd5;
    localparam logic [7:0] BOTH_DEBOUNCE_RESET   = 8'd20;
    localparam logic [7:0] DEFAULT_COMPARE_RESET = 8'd49;
    localparam logic [7:0] COMPARE_STEP_RESET    = 8'd1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE_DEBOUNCE   = 2'd0,
        CFG_BOTH_DEBOUNCE   = 2'd1,
        CFG_DEFAULT_COMPARE = 2'd2,
        CFG_COMPARE_STEP    = 2'd3
    } cfg_idx_t;

    // item kinds
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration bundle
    typedef struct packed {
        logic [7:0] base_debounce;
        logic [7:0] both_debounce;
        logic [7:0] default_compare;
        logic [7:0] compare_step;
    } bdra_cfg_t;

endpackage : bdra_pkg
`default_nettype wire

FILE: hw/rtl/bdra_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdra_cfg
// Configuration register file: four 8-bit registers written through a plain
// write port, presented to the core as one bundle.
// ----------------------------------------------------------------------------
module bdra_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    output bdra_pkg::bdra_cfg_t   cfg
);
    import bdra_pkg::*;

    bdra_cfg_t cfg_reg;
    bdra_cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_DEBOUNCE:   cfg_next.base_debounce   = cfg_data;
                CFG_BOTH_DEBOUNCE:   cfg_next.both_debounce   = cfg_data;
                CFG_DEFAULT_COMPARE: cfg_next.default_compare = cfg_data;
                CFG_COMPARE_STEP:    cfg_next.compare_step    = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_debounce   <= BASE_DEBOUNCE_RESET;
            cfg_reg.both_debounce   <= BOTH_DEBOUNCE_RESET;
            cfg_reg.default_compare <= DEFAULT_COMPARE_RESET;
            cfg_reg.compare_step    <= COMPARE_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : bdra_cfg
`default_nettype wire

FILE: hw/rtl/bdra_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdra_core
// Debounce and timer state. Works out the result of the item held in the
// input register and commits the new state when that item moves on.
// ----------------------------------------------------------------------------
module bdra_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             req_type,
    input  wire logic             inc_pressed,
    input  wire logic             dec_pressed,
    input  wire bdra_pkg::bdra_cfg_t cfg,
    output logic [7:0]            compare_value,
    output logic                  led_level,
    output logic                  accepted
);
    import bdra_pkg::*;

    logic [1:0] accepted_buttons_reg, accepted_buttons_next;
    logic [1:0] previous_sample_reg,  previous_sample_next;
    logic [7:0] stable_count_reg,     stable_count_next;
    logic [7:0] active_threshold_reg, active_threshold_next;
    logic [7:0] compare_reg,          compare_next;
    logic [7:0] timer_count_reg,      timer_count_next;
    logic       led_reg,              led_next;

    logic [1:0] sample;
    logic [7:0] count_upd;
    logic       differs;
    logic       take;

    // debounce of the button pair and timer compare
    always_comb
    begin
        accepted_buttons_next = accepted_buttons_reg;
        previous_sample_next  = previous_sample_reg;
        stable_count_next     = stable_count_reg;
        active_threshold_next = active_threshold_reg;
        compare_next          = compare_reg;
        timer_count_next      = timer_count_reg;
        led_next              = led_reg;

        sample  = {inc_pressed, dec_pressed};
        differs = (accepted_buttons_reg != sample);

        // stability counter restarts on a changed sample
        if (sample == previous_sample_reg)
            count_upd = differs ? stable_count_reg + 8'd1 : stable_count_reg;
        else
            count_upd = 8'd0;

        take = (req_type == REQ_POLL) && differs && (active_threshold_reg < count_upd);

        if (req_type == REQ_TICK)
        begin
            // clear-on-match timer, led toggles on a match
            if (timer_count_reg == compare_reg)
            begin
                timer_count_next = 8'd0;
                led_next         = ~led_reg;
            end
            else
            begin
                timer_count_next = timer_count_reg + 8'd1;
            end
        end
        else
        begin
            stable_count_next    = count_upd;
            previous_sample_next = sample;
            if (take)
            begin
                accepted_buttons_next = sample;
                active_threshold_next = cfg.base_debounce;
                if (inc_pressed && dec_pressed)
                begin
                    compare_next          = cfg.default_compare;
                    active_threshold_next = cfg.both_debounce;
                end
                else if (inc_pressed)
                begin
                    compare_next = compare_reg - cfg.compare_step;
                end
                else if (dec_pressed)
                begin
                    compare_next = compare_reg + cfg.compare_step;
                end
            end
        end
    end

    // state commits when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_buttons_reg <= 2'd0;
            previous_sample_reg  <= 2'd0;
            stable_count_reg     <= 8'd0;
            active_threshold_reg <= BASE_DEBOUNCE_RESET;
            compare_reg          <= DEFAULT_COMPARE_RESET;
            timer_count_reg      <= 8'd0;
            led_reg              <= 1'b0;
        end
        else if (advance)
        begin
            accepted_buttons_reg <= accepted_buttons_next;
            previous_sample_reg  <= previous_sample_next;
            stable_count_reg     <= stable_count_next;
            active_threshold_reg <= active_threshold_next;
            compare_reg          <= compare_next;
            timer_count_reg      <= timer_count_next;
            led_reg              <= led_next;
        end
    end

    assign compare_value = compare_next;
    assign led_level     = led_next;
    assign accepted      = take;

endmodule : bdra_core
`default_nettype wire

FILE: hw/rtl/button_debounce_rate_adjust.sv
`default_nettype none
// An item passes from input accept to result valid through the input register,
// then the result register. Throughput: one item per clock while out_stall is
// low; the bound is the debounce/timer state update in the core.
// A stalled result holds while the input register still takes one item.
// Reset (rst_n low, asynchronous): registers to defaults, state to none
// pressed with counters, led and pipeline valids cleared.
// ----------------------------------------------------------------------------
// button_debounce_rate_adjust
// Button pair debounce with timer compare adjust and led toggle, behind an
// input register and a result register with valid/stall handshakes.
// ----------------------------------------------------------------------------
module button_debounce_rate_adjust (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       req_type,
    input  wire logic       inc_pressed,
    input  wire logic       dec_pressed,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      compare_value,
    output logic            led_level,
    output logic            accepted,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import bdra_pkg::*;

    bdra_cfg_t  cfg;

    logic       in_valid_reg, in_valid_next;
    logic       req_type_reg, inc_reg, dec_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] cmp_out_reg;
    logic       led_out_reg;
    logic       acc_out_reg;

    logic       advance;
    logic       in_take;
    logic [7:0] core_compare;
    logic       core_led;
    logic       core_accepted;

    // handshake control
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // configuration registers
    bdra_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // debounce and timer state
    bdra_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .req_type      (req_type_reg),
        .inc_pressed   (inc_reg),
        .dec_pressed   (dec_reg),
        .cfg           (cfg),
        .compare_value (core_compare),
        .led_level     (core_led),
        .accepted      (core_accepted)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg <= req_type;
            inc_reg      <= inc_pressed;
            dec_reg      <= dec_pressed;
        end
    end

    // result item register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmp_out_reg <= core_compare;
            led_out_reg <= core_led;
            acc_out_reg <= core_accepted;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = cmp_out_reg;
    assign led_level     = led_out_reg;
    assign accepted      = acc_out_reg;

endmodule : button_debounce_rate_adjust
`default_nettype wire

FILE: hw/rtl/bdra_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdra_checker
// Port-level checks for the button debounce and rate adjust block, bound to
// the top level.
// ----------------------------------------------------------------------------
module bdra_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] compare_value,
    input wire logic       led_level,
    input wire logic       accepted
);
    logic [7:0] last_cmp_reg;
    logic       have_last_reg;

    // compare value of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg <= 1'b0;
            last_cmp_reg  <= 8'd0;
        end
        else if (out_valid && !out_stall)
        begin
            have_last_reg <= 1'b1;
            last_cmp_reg  <= compare_value;
        end
    end

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(compare_value)
            && $stable(led_level) && $stable(accepted))
        else $error("stalled result item changed");

    // an empty result register never holds back the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with result register empty");

    // an accepted item reaches the output when not held back
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("item did not reach the result register");

    // compare value only moves on an accepted button state
    a_cmp_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted && have_last_reg |-> compare_value == last_cmp_reg)
        else $error("compare value changed without an accepted state");

endmodule : bdra_checker

bind button_debounce_rate_adjust bdra_checker u_bdra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_value (compare_value),
    .led_level     (led_level),
    .accepted      (accepted)
);
`default_nettype wire
